### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the min tracking stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/mts_pkg.sv
// Types and constants of the min tracking stack.
package mts_pkg;

    localparam int CMD_W    = 2;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    // Command codes of a request.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // Status codes of a result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control states of the top level.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FILL = 2'd1,
        S_SEND = 2'd2
    } t_state;

    // One result as held in the output register.
    typedef struct packed {
        logic signed [FIELD_W-1:0] top_value;
        logic signed [FIELD_W-1:0] min_value;
        logic                      is_empty;
        t_status                   status;
    } t_result;

endpackage

### hw/rtl/mts_if.sv
// Request and result channel interfaces of the min tracking stack.
interface mts_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [mts_pkg::CMD_W-1:0]              command;
    logic signed [mts_pkg::FIELD_W-1:0]     value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface mts_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mts_pkg::FIELD_W-1:0]     top_value;
    logic signed [mts_pkg::FIELD_W-1:0]     min_value;
    logic                                   is_empty;
    logic [mts_pkg::STATUS_W-1:0]           status;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input is_empty,
                    input status, output ready);
endinterface

### hw/rtl/mts_ram.sv
// Simple dual-port stack memory with one write port and a registered read port.
module mts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/min_tracking_stack.sv
// Min tracking stack: push, pop and peek with the running minimum of the stored values.
// Push, peek, any ignored request and a pop of the last value have their result
// registered in the cycle after acceptance. A pop that leaves values behind reads the
// new tops from the read port in S_FILL and sends them in S_SEND once the output is free.
// Synchronous active-low reset empties both stacks and drops any pending result;
// the memories are not cleared, since only entries below the counts are ever read.
module min_tracking_stack #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mts_req_if.sink    i_req,
    mts_rsp_if.source  o_rsp
);
    import mts_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [CW-1:0] CNT_ZERO = '0;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_dcount, n_dcount;
    logic [CW-1:0]                r_mcount, n_mcount;
    logic signed [DATA_WIDTH-1:0] r_dtop, n_dtop;
    logic signed [DATA_WIDTH-1:0] r_mtop, n_mtop;
    logic                         r_fill_m, n_fill_m;
    t_status                      r_status, n_status;
    t_result                      r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic signed [DATA_WIDTH-1:0] push_val;
    logic                         slot_free;
    logic                         fire;
    logic                         load;
    logic [CW-1:0]                d_less2, m_less2;

    logic                  d_we, m_we;
    logic [AW-1:0]         d_waddr, m_waddr, d_raddr, m_raddr;
    logic [DATA_WIDTH-1:0] d_rdata, m_rdata;

    // Builds a result from the counts and cached tops; an empty stack reads as zero.
    function automatic t_result make_result(input logic [CW-1:0] dc,
                                            input logic [CW-1:0] mc,
                                            input logic signed [DATA_WIDTH-1:0] dt,
                                            input logic signed [DATA_WIDTH-1:0] mt,
                                            input t_status st);
        t_result res;
        res.status    = st;
        res.is_empty  = (dc == CNT_ZERO);
        res.top_value = (dc == CNT_ZERO) ? '0 : FIELD_W'(dt);
        res.min_value = (dc == CNT_ZERO || mc == CNT_ZERO) ? '0 : FIELD_W'(mt);
        return res;
    endfunction

    // The pushed value is sign-extended or cut to the stored width.
    assign push_val  = DATA_WIDTH'(i_req.value);
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign fire      = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE) && slot_free;

    // Memory addresses: writes go to the next free entry, reads fetch the entry below the top.
    assign d_less2 = r_dcount - CNT_TWO;
    assign m_less2 = r_mcount - CNT_TWO;
    assign d_waddr = r_dcount[AW-1:0];
    assign m_waddr = r_mcount[AW-1:0];
    assign d_raddr = d_less2[AW-1:0];
    assign m_raddr = m_less2[AW-1:0];

    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (push_val),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (push_val),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Next state, stack updates and result formation.
    always_comb begin
        n_state     = r_state;
        n_dcount    = r_dcount;
        n_mcount    = r_mcount;
        n_dtop      = r_dtop;
        n_mtop      = r_mtop;
        n_fill_m    = r_fill_m;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        d_we        = 1'b0;
        m_we        = 1'b0;
        load        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (fire) begin
                    n_status = ST_OK;
                    load     = 1'b1;
                    unique case (t_cmd'(i_req.command))
                        CMD_PUSH: begin
                            if (r_dcount == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                d_we     = 1'b1;
                                n_dcount = r_dcount + CNT_ONE;
                                n_dtop   = push_val;
                                if ((r_mcount == CNT_ZERO || push_val <= r_mtop) &&
                                    r_mcount != CNT_FULL) begin
                                    m_we     = 1'b1;
                                    n_mcount = r_mcount + CNT_ONE;
                                    n_mtop   = push_val;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (r_dcount == CNT_ZERO) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_dcount = r_dcount - CNT_ONE;
                                n_fill_m = 1'b0;
                                if (r_mcount != CNT_ZERO && r_dtop == r_mtop) begin
                                    n_mcount = r_mcount - CNT_ONE;
                                    n_fill_m = (r_mcount > CNT_ONE);
                                end
                                // Values remain below: wait for the memory to return them.
                                if (r_dcount > CNT_ONE) begin
                                    load    = 1'b0;
                                    n_state = S_FILL;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (load) begin
                        n_out       = make_result(n_dcount, n_mcount, n_dtop, n_mtop, n_status);
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_FILL: begin
                n_dtop = $signed(d_rdata);
                if (r_fill_m) begin
                    n_mtop = $signed(m_rdata);
                end
                n_state = S_SEND;
            end
            S_SEND: begin
                if (slot_free) begin
                    n_out       = make_result(r_dcount, r_mcount, r_dtop, r_mtop, r_status);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dcount    <= '0;
            r_mcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dcount    <= n_dcount;
            r_mcount    <= n_mcount;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dtop   <= n_dtop;
        r_mtop   <= n_mtop;
        r_fill_m <= n_fill_m;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.top_value = r_out.top_value;
    assign o_rsp.min_value = r_out.min_value;
    assign o_rsp.is_empty  = r_out.is_empty;
    assign o_rsp.status    = r_out.status;

    // The minimum stack never holds more entries than the data stack.
    `MTS_ASSERT_IMP(a_min_le_data, i_clk, i_rst_n, 1'b1, r_mcount <= r_dcount)
    // A non-empty stack always has a minimum.
    `MTS_ASSERT_IMP(a_min_present, i_clk, i_rst_n, r_dcount != CNT_ZERO, r_mcount != CNT_ZERO)
    // An empty result reports zero for both values.
    `MTS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_out_valid && r_out.is_empty, r_out.top_value == '0 && r_out.min_value == '0)
    // A refill always moves on to sending its result.
    `MTS_ASSERT_NXT(a_fill_send, i_clk, i_rst_n, r_state == S_FILL, r_state == S_SEND)

endmodule

### verif/testbench.sv
// Self-checking testbench for the min tracking stack.
`timescale 1ns / 100ps

module testbench;

    import mts_pkg::*;

    localparam int STACK_DEPTH   = 64;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 85;

    // Command code 3 has no meaning and must behave as a peek.
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [FIELD_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] VAL_MIN    = 32'h8000_0000;

    logic i_clk;
    logic i_rst_n;

    mts_req_if req_if ();
    mts_rsp_if rsp_if ();

    min_tracking_stack #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (FIELD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Idle and stall rates in percent, and a pending long hold-off of the receiver.
    int req_idle_pct        = 0;
    int rsp_stall_pct       = 0;
    int hold_request_cycles = 0;
    int mismatch_count      = 0;
    int cycle_count         = 0;

    // Shadow copy of both stacks, updated as requests are accepted.
    logic signed [FIELD_W-1:0] shadow_data [STACK_DEPTH];
    logic signed [FIELD_W-1:0] shadow_mins [STACK_DEPTH];
    int data_depth = 0;
    int min_depth  = 0;

    // Tops and minima predicted for accepted requests, oldest first.
    t_result predicted_tops [$];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Applies one request to the shadow stacks and returns the view it should produce.
    function automatic t_result shadow_stack_step(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [FIELD_W-1:0] val);
        t_result view;
        view.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (data_depth >= STACK_DEPTH) begin
                view.status = ST_FULL;
            end else begin
                shadow_data[data_depth] = val;
                data_depth++;
                // Equal values are stacked too, so a duplicate minimum survives one pop.
                if (min_depth == 0 || val <= shadow_mins[min_depth-1]) begin
                    shadow_mins[min_depth] = val;
                    min_depth++;
                end
            end
        end else if (cmd == CMD_POP) begin
            if (data_depth == 0) begin
                view.status = ST_EMPTY;
            end else begin
                if (min_depth > 0 && shadow_data[data_depth-1] == shadow_mins[min_depth-1])
                    min_depth--;
                data_depth--;
            end
        end
        if (data_depth == 0) begin
            view.top_value = '0;
            view.min_value = '0;
            view.is_empty  = 1'b1;
        end else begin
            view.top_value = shadow_data[data_depth-1];
            view.min_value = (min_depth > 0) ? shadow_mins[min_depth-1] : '0;
            view.is_empty  = 1'b0;
        end
        return view;
    endfunction

    task automatic report_mismatch(input string field_name, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d (%h), got %0d (%h)", $time, field_name,
                     $signed(want), want, $signed(got), got);
    endtask

    // Request and result monitor: predicts on each accepted request, checks each result.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                predicted_tops.push_back(shadow_stack_step(req_if.command, req_if.value));
            if (rsp_if.valid && rsp_if.ready) begin
                got.top_value = rsp_if.top_value;
                got.min_value = rsp_if.min_value;
                got.is_empty  = rsp_if.is_empty;
                got.status    = t_status'(rsp_if.status);
                if (predicted_tops.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: top %0d min %0d",
                                 $time, got.top_value, got.min_value);
                end else begin
                    want = predicted_tops.pop_front();
                    if (got.top_value !== want.top_value)
                        report_mismatch("top_value", want.top_value, got.top_value);
                    if (got.min_value !== want.min_value)
                        report_mismatch("min_value", want.min_value, got.min_value);
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", FIELD_W'(want.is_empty),
                                        FIELD_W'(got.is_empty));
                    if (got.status !== want.status)
                        report_mismatch("status", FIELD_W'(want.status), FIELD_W'(got.status));
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request_cycles > 0) begin
                hold_left           = hold_request_cycles;
                hold_request_cycles = 0;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Offers one request after a random gap and returns at the edge that accepts it.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [FIELD_W-1:0] val);
        while ($urandom_range(99) < req_idle_pct) begin
            // Noise on the payload while valid is low must be ignored.
            req_if.valid   <= 1'b0;
            req_if.command <= CMD_W'($urandom);
            req_if.value   <= $urandom;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.value   <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Small values in four cases of ten, so that duplicates and equal minima are common.
    function automatic logic signed [FIELD_W-1:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return int'($urandom_range(16)) - 8;
            4: begin
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] random_command(input int push_pct);
        int pick;
        if ($urandom_range(99) < push_pct)
            return CMD_PUSH;
        pick = $urandom_range(9);
        if (pick < 7)
            return CMD_POP;
        else if (pick < 9)
            return CMD_PEEK;
        else
            return CMD_UNUSED;
    endfunction

    task automatic set_idling(input int idle_pct, input int stall_pct);
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
    endtask

    // Pop, peek and the unused code on an empty stack.
    task automatic test_empty_stack();
        send_request(CMD_POP, '0);
        send_request(CMD_PEEK, '1);
        send_request(CMD_UNUSED, VAL_MAX);
    endtask

    // Extreme values, equal minima and a full unwind back past empty.
    task automatic test_value_extremes();
        send_request(CMD_PUSH, VAL_MAX);
        send_request(CMD_PUSH, 5);
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_PUSH, -1);
        send_request(CMD_PUSH, 0);
        send_request(CMD_PEEK, 1234);
        send_request(CMD_UNUSED, VAL_MIN);
        repeat (7) send_request(CMD_POP, VAL_MAX);
        send_request(CMD_PUSH, 0);
        send_request(CMD_PUSH, 0);
        send_request(CMD_POP, 0);
        send_request(CMD_POP, 0);
    endtask

    // The receiver holds off while pushes keep coming: the block backs up, then
    // the stack fills and further pushes are refused. Pops then drain it past empty.
    task automatic test_fill_under_backpressure();
        set_idling(0, 0);
        hold_request_cycles = HOLD_CYCLES;
        repeat (STACK_DEPTH + 6) send_request(CMD_PUSH, random_value());
        repeat (STACK_DEPTH + 2) send_request(CMD_POP, random_value());
    endtask

    // Random traffic in bursts that lean toward pushes or pops, so the depth swings widely.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int push_pct;
        set_idling(idle_pct, stall_pct);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) begin
                case ($urandom_range(3))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    2:       push_pct = 80;
                    default: push_pct = 95;
                endcase
            end
            send_request(random_command(push_pct), random_value());
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.command = CMD_PEEK;
        req_if.value   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_value_extremes();
        test_fill_under_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(67, 0);
        test_random_traffic(0, 67);
        test_random_traffic(25, 25);

        req_if.valid <= 1'b0;
        while (predicted_tops.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
